// File: rtl/sfpbd_pkg.sv
package sfpbd_pkg;

   localparam int unsigned WORD_W = 32;

   localparam logic [4:0]        WARMUP_ROUNDS = 5'd20;
   localparam logic [WORD_W-1:0] SEED_A_INIT   = 32'hf1ea5eed;
   localparam logic [WORD_W-1:0] FULL_WORD     = 32'hffffffff;

   // Generator state: the four words of the small fast generator.
   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
      logic [WORD_W-1:0] d;
   } gen_state_type;

   // One queued item: its bound and whether it asks for a raw word.
   typedef struct packed {
      logic              raw;
      logic [WORD_W-1:0] bound;
   } q_entry_type;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] dividend;
      logic [WORD_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPLIT,
      ST_DRAW,
      ST_DIVS,
      ST_DIVW,
      ST_EMIT
   } back_state_type;

   function automatic gen_state_type gen_seed(input logic [WORD_W-1:0] s);
      gen_state_type g;
      g.a = SEED_A_INIT;
      g.b = s;
      g.c = s;
      g.d = s;
      return g;
   endfunction

   // One round of the generator.
   function automatic gen_state_type gen_advance(input gen_state_type g);
      logic [WORD_W-1:0] e;
      gen_state_type     n;
      e   = g.a - {g.b[4:0], g.b[31:5]};
      n.a = g.b ^ {g.c[14:0], g.c[31:15]};
      n.b = g.c + g.d;
      n.c = g.d + e;
      n.d = e + n.a;
      return n;
   endfunction

endpackage

// File: rtl/sfpbd_front.sv
module sfpbd_front
   import sfpbd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [WORD_W-1:0] req_tdata,
   output logic              q_valid,
   output q_entry_type       q_head,
   input  logic              q_pop
);

   // Two-entry queue between the input side and the draw engine.
   q_entry_type entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   logic        pop;

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign pop        = q_pop && q_valid;
   assign q_head     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // A zero bound is classified here as a request for the raw word.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff].raw   <= (req_tdata == '0);
         entry_ff[wr_ptr_ff].bound <= req_tdata;
      end
   end

endmodule

// File: rtl/sfpbd_div.sv
module sfpbd_div
   import sfpbd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   // Restoring divider, one quotient bit per cycle.
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] quo_ff, quo_in;
   logic [WORD_W-1:0] dvs_ff;
   logic [5:0]        count_ff, count_in;
   logic              done_ff, done_in;
   logic [WORD_W:0]   shifted;
   logic [WORD_W:0]   diff;

   assign shifted = {rem_ff, quo_ff[WORD_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (req.start) begin
         rem_in   = '0;
         quo_in   = req.dividend;
         count_in = 6'(WORD_W);
      end else if (count_ff != 6'd0) begin
         if (!diff[WORD_W]) begin
            rem_in = diff[WORD_W-1:0];
         end else begin
            rem_in = shifted[WORD_W-1:0];
         end
         quo_in   = {quo_ff[WORD_W-2:0], ~diff[WORD_W]};
         count_in = count_ff - 6'd1;
         done_in  = (count_ff == 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 6'd0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (req.start) begin
         dvs_ff <= req.divisor;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// File: rtl/sfpbd_back.sv
module sfpbd_back
   import sfpbd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [WORD_W-1:0] csr_wdata,
   input  logic              q_valid,
   input  q_entry_type       q_head,
   output logic              q_pop,
   output div_req_type       div_req,
   input  div_rsp_type       div_rsp,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [WORD_W-1:0] rsp_tdata
);

   back_state_type    state_ff, state_in;
   gen_state_type     gen_ff;
   logic [4:0]        warm_ff;
   logic              raw_ff;
   logic [WORD_W-1:0] bound_ff;
   logic [WORD_W-1:0] split_ff;
   logic [WORD_W-1:0] result_ff;
   logic              rsp_tvalid_ff;
   logic [WORD_W-1:0] rsp_tdata_ff;

   logic do_advance;
   logic do_warm;
   logic load_split;
   logic load_result;
   logic load_out;
   logic out_free;
   logic accept_q;

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign accept_q = (warm_ff == 5'd0) && q_valid;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept_q) begin
               state_in = q_head.raw ? ST_DRAW : ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            if (div_rsp.done) begin
               state_in = ST_DRAW;
            end
         end
         ST_DRAW: begin
            state_in = raw_ff ? ST_EMIT : ST_DIVS;
         end
         ST_DIVS: begin
            state_in = ST_DIVW;
         end
         ST_DIVW: begin
            if (div_rsp.done) begin
               state_in = (div_rsp.quotient < bound_ff) ? ST_EMIT : ST_DRAW;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      do_advance  = 1'b0;
      do_warm     = 1'b0;
      load_split  = 1'b0;
      load_result = 1'b0;
      load_out    = 1'b0;
      q_pop       = 1'b0;
      div_req     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (warm_ff != 5'd0) begin
               do_warm    = 1'b1;
               do_advance = 1'b1;
            end else if (q_valid) begin
               q_pop            = 1'b1;
               div_req.start    = !q_head.raw;
               div_req.dividend = FULL_WORD;
               div_req.divisor  = q_head.bound;
            end
         end
         ST_SPLIT: begin
            load_split = div_rsp.done;
         end
         ST_DRAW: begin
            do_advance = 1'b1;
         end
         ST_DIVS: begin
            div_req.start    = 1'b1;
            div_req.dividend = gen_ff.d;
            div_req.divisor  = split_ff;
         end
         ST_DIVW: begin
            load_result = div_rsp.done && (div_rsp.quotient < bound_ff);
         end
         ST_EMIT: begin
            load_out = out_free;
         end
         default: begin
            do_advance = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         gen_ff        <= gen_seed('0);
         warm_ff       <= WARMUP_ROUNDS;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            gen_ff  <= gen_seed(csr_wdata);
            warm_ff <= WARMUP_ROUNDS;
         end else if (do_advance) begin
            gen_ff <= gen_advance(gen_ff);
            if (do_warm) begin
               warm_ff <= warm_ff - 5'd1;
            end
         end
         if (load_out) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         raw_ff   <= q_head.raw;
         bound_ff <= q_head.bound;
      end
      if (load_split) begin
         split_ff <= div_rsp.quotient;
      end
      if (load_result) begin
         result_ff <= div_rsp.quotient;
      end
      if (load_out) begin
         rsp_tdata_ff <= raw_ff ? gen_ff.d : result_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// File: rtl/small_fast_prng_bounded_draw.sv
// Channel     Direction  Handshake               Payload
// req_        in         req_tvalid/req_tready   req_tdata[31:0] = range
// rsp_        out        rsp_tvalid/rsp_tready   rsp_tdata[31:0] = value
// csr_        in         csr_we                  csr_wdata[31:0] = seed_value
//
// A nonzero range first computes the split in the shared one-bit-per-cycle divider,
// then makes generator draws (one round, a divider start and a full division),
// repeated for each rejected quotient. A zero range returns the word of one round.
// Reset or a seed write arms 20 warm-up rounds, one per cycle, run before the next
// item is started. Results leave through an output register, so a stalled result
// side does not stop the two-item input queue from filling.
module small_fast_prng_bounded_draw
   import sfpbd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [WORD_W-1:0] req_tdata,   // [31:0] range
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [WORD_W-1:0] rsp_tdata,   // [31:0] value
   input  logic              csr_we,
   input  logic [WORD_W-1:0] csr_wdata
);

   // The front end queues each item and marks a zero range as a raw-word request.
   logic        q_valid;
   q_entry_type q_head;
   logic        q_pop;

   // The back end owns the generator and drives the shared divider, which serves
   // both the split computation and the per-draw quotient.
   div_req_type div_req;
   div_rsp_type div_rsp;

   sfpbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop)
   );

   sfpbd_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   sfpbd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: rtl/sfpbd_checker.sv
module sfpbd_checker
   import sfpbd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [WORD_W-1:0] rsp_tdata
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // A stalled result keeps its value.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Reset leaves no result on offer.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // The handshake outputs are always driven to known levels out of reset.
   a_handshake_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_tready, rsp_tvalid}))
      else $error("handshake output unknown");

endmodule

bind small_fast_prng_bounded_draw sfpbd_checker u_sfpbd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: tb/small_fast_prng_bounded_draw_tb.sv
`timescale 1ns / 100ps

// Checks the bounded draw block against an internal copy of the generator.
// Every range item accepted on the request side is run through the predictor
// at the moment of acceptance. The predicted draw is queued and compared with
// the next value accepted on the response side. Seed writes happen only while
// no item is in flight, and they reload the predictor at the same time.
module small_fast_prng_bounded_draw_tb;
   import sfpbd_pkg::*;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [WORD_W-1:0] req_tdata  = '0;   // [31:0] range
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [WORD_W-1:0] rsp_tdata;         // [31:0] value
   logic              csr_we     = 1'b0;
   logic [WORD_W-1:0] csr_wdata  = '0;   // [31:0] seed_value

   // Ranges waiting to be presented, and the draws that the block owes us.
   logic [WORD_W-1:0] pending_ranges[$];
   logic [WORD_W-1:0] expected_draws[$];

   // Predictor state: the four generator words and the warm-up rounds still
   // to run before the next draw.
   gen_state_type gen;
   int unsigned   warm_pending;

   int unsigned error_count = 0;

   // While set, neither side inserts gaps or stalls.
   bit no_gaps = 1'b0;

   small_fast_prng_bounded_draw DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [WORD_W-1:0] rotate_left(input logic [WORD_W-1:0] v,
                                                     input int k);
      return (v << k) | (v >> (WORD_W - k));
   endfunction

   // One generator round; returns the new fourth word, which is the output.
   function automatic logic [WORD_W-1:0] next_word();
      logic [WORD_W-1:0] e;
      e     = gen.a - rotate_left(gen.b, 27);
      gen.a = gen.b ^ rotate_left(gen.c, 17);
      gen.b = gen.c + gen.d;
      gen.c = gen.d + e;
      gen.d = e + gen.a;
      return gen.d;
   endfunction

   // A seed loads the last three words and arms the warm-up again.
   function automatic void reseed(input logic [WORD_W-1:0] s);
      gen.a        = SEED_A_INIT;
      gen.b        = s;
      gen.c        = s;
      gen.d        = s;
      warm_pending = WARMUP_ROUNDS;
   endfunction

   // Draw for one range. Pending warm-up rounds are burned first. A zero
   // range hands back the raw word. Otherwise each word is divided by the
   // split and the quotient is retried until it lands below the range, so a
   // rejected quotient costs exactly one more round.
   function automatic logic [WORD_W-1:0] predict_draw(input logic [WORD_W-1:0] bound);
      logic [WORD_W-1:0] split;
      logic [WORD_W-1:0] quot;
      while (warm_pending != 0) begin
         void'(next_word());
         warm_pending--;
      end
      if (bound == 0)
         return next_word();
      split = FULL_WORD / bound;
      do
         quot = next_word() / split;
      while (quot >= bound);
      return quot;
   endfunction

   // Request driver. An item is presented once the previous one has been
   // taken; about one time in five the slot is left empty instead. The
   // prediction is made at the edge where the block accepts the item, so
   // the expected draws stay in acceptance order.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_draws.push_back(predict_draw(req_tdata));
         if (!req_tvalid || req_tready) begin
            if (pending_ranges.size() != 0 &&
                (no_gaps || $urandom_range(0, 99) >= 20)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_ranges.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. It stalls the result side at random and compares each
   // accepted value with the oldest expected draw.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_draws.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: value %h arrived with no draw expected", $time, rsp_tdata);
            end else if (rsp_tdata !== expected_draws[0]) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: value mismatch, expected %h, got %h",
                           $time, expected_draws[0], rsp_tdata);
               void'(expected_draws.pop_front());
            end else begin
               void'(expected_draws.pop_front());
            end
         end
         rsp_tready <= no_gaps || ($urandom_range(0, 99) >= 20);
      end
   end

   // Waits until every queued range has been taken and every draw has come
   // back, then lets the block settle before the next seed.
   task automatic drain();
      while (pending_ranges.size() != 0 || req_tvalid || expected_draws.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_seed(input logic [WORD_W-1:0] s);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= s;
      reseed(s);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Queues random ranges. Small ranges dominate; ranges just above half the
   // word force frequent rejections, ranges near the top of the word rare
   // ones, and fully random ranges exercise every bit of the field.
   task automatic queue_random(input int count);
      logic [WORD_W-1:0] r;
      int unsigned       pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 10)
            r = '0;
         else if (pick < 40)
            r = $urandom_range(1, 20);
         else if (pick < 60)
            r = $urandom;
         else if (pick < 75)
            r = (32'd1 << $urandom_range(0, 31)) + $urandom_range(0, 2) - 1;
         else if (pick < 85)
            r = 32'h8000_0000 + $urandom_range(0, 255);
         else
            r = FULL_WORD - $urandom_range(0, 255);
         pending_ranges.push_back(r);
      end
   endtask

   initial begin
      logic [WORD_W-1:0] corner_ranges[] = '{
         32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
         32'h0000_0006, 32'h0000_0010, 32'h0000_03e8, 32'h0001_0000,
         32'h5555_5555, 32'h5555_5556, 32'h7fff_ffff, 32'h8000_0000,
         32'h8000_0001, 32'haaaa_aaaa, 32'hc000_0000, 32'hffff_fffe,
         32'hffff_ffff, 32'h0000_0000, 32'h0000_0001
      };

      // The block comes out of reset seeded with zero.
      reseed('0);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Corner ranges first: zero for the raw word, one, powers of two, the
      // split boundaries around a third and a half, and the top of the word.
      foreach (corner_ranges[i])
         pending_ranges.push_back(corner_ranges[i]);
      drain();

      // Highest seed, then an explicit zero seed, which must not be replaced
      // by anything else.
      write_seed(FULL_WORD);
      queue_random(140);
      drain();

      write_seed('0);
      queue_random(140);
      drain();

      // Two writes in a row: only the second seed should count.
      write_seed($urandom);
      write_seed($urandom);
      no_gaps = 1'b1;
      queue_random(150);
      drain();
      no_gaps = 1'b0;

      write_seed(32'h0000_0001);
      queue_random(110);
      drain();

      write_seed(32'h8000_0000);
      queue_random(100);
      drain();

      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run of this stimulus.
   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: filelist.f
rtl/sfpbd_pkg.sv
rtl/sfpbd_front.sv
rtl/sfpbd_div.sv
rtl/sfpbd_back.sv
rtl/small_fast_prng_bounded_draw.sv
rtl/sfpbd_checker.sv
tb/small_fast_prng_bounded_draw_tb.sv
